@@ hw/rtl/ptcq_pkg.sv @@
// package for the phased timed callback queue
// types, codes and sizes shared by the cell, the queue and the core
`default_nettype none
package ptcq_pkg;

  localparam int CLIENTS     = 16;
  localparam int QDEPTH      = 16;
  localparam int PHASES      = 4;
  localparam int MAX_RESULTS = 32;

  localparam int CID_W  = 4;
  localparam int PH_W   = 2;
  localparam int TIME_W = 32;
  localparam int CNT_W  = $clog2(QDEPTH + 1);
  localparam int SCAN_W = $clog2(CLIENTS);
  localparam int K_W    = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    CMD_ADD, CMD_REMOVE, CMD_SCHEDULE, CMD_CANCEL, CMD_TICK
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_EVERY, KIND_ONESHOT, KIND_ACK
  } kind_e;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_EVERY, S_POP, S_CANCEL, S_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [CID_W-1:0]  owner;
  } entry_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic              pop_mode;
    logic [TIME_W-1:0] dl;
    logic [CID_W-1:0]  cid;
  } qctl_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [PH_W-1:0]   phase;
    logic [CID_W-1:0]  client_id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] now;
  } in_t;

  typedef struct packed {
    logic [CID_W-1:0] fired_client;
    logic [1:0]       fire_kind;
    logic             status;
    logic             last;
  } out_t;

endpackage
`default_nettype wire

@@ hw/rtl/ptcq_cell.sv @@
// one slot of a deadline-sorted one-shot queue
// depends on ptcq_pkg; talks to its left and right neighbor slots
`default_nettype none
module ptcq_cell (
  input  wire logic            clk,
  input  wire ptcq_pkg::qctl_t ctl,
  input  wire logic            occ,
  input  wire ptcq_pkg::entry_t left_ent,
  input  wire ptcq_pkg::entry_t right_ent,
  input  wire logic            left_keep,
  input  wire logic            left_hit,
  output ptcq_pkg::entry_t     ent,
  output logic                 keep,
  output logic                 hit
);
  import ptcq_pkg::*;

  entry_t ent_r, ent_nxt;

  assign keep = occ && (ent_r.deadline <= ctl.dl);
  assign hit  = left_hit || (occ && (ctl.pop_mode || (ent_r.owner == ctl.cid)));
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (!keep) begin
        if (left_keep) begin
          ent_nxt.deadline = ctl.dl;
          ent_nxt.owner    = ctl.cid;
        end else begin
          ent_nxt = left_ent;
        end
      end
    end else if (ctl.del && hit) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/ptcq_queue.sv @@
// one phase's one-shot queue: a chain of slots plus the fill count
// depends on ptcq_pkg and ptcq_cell
`default_nettype none
module ptcq_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ptcq_pkg::qctl_t           ctl,
  output ptcq_pkg::entry_t               head,
  output logic [ptcq_pkg::CNT_W-1:0]     cnt,
  output logic                           any_hit
);
  import ptcq_pkg::*;

  entry_t               ent  [QDEPTH];
  logic   [QDEPTH-1:0]  keep;
  logic   [QDEPTH-1:0]  hit;
  logic   [CNT_W-1:0]   cnt_r, cnt_nxt;

  for (genvar i = 0; i < QDEPTH; i++) begin : g_cell
    logic   occ;
    entry_t l_ent, r_ent;
    logic   l_keep, l_hit;
    assign occ = (CNT_W'(i) < cnt_r);
    if (i == 0) begin : g_first
      assign l_ent  = ent[0];
      assign l_keep = 1'b1;
      assign l_hit  = 1'b0;
    end else begin : g_mid
      assign l_ent  = ent[i-1];
      assign l_keep = keep[i-1];
      assign l_hit  = hit[i-1];
    end
    if (i == QDEPTH - 1) begin : g_tail
      assign r_ent = ent[i];
    end else begin : g_body
      assign r_ent = ent[i+1];
    end
    ptcq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .left_keep (l_keep),
      .left_hit  (l_hit),
      .ent       (ent[i]),
      .keep      (keep[i]),
      .hit       (hit[i])
    );
  end

  assign head    = ent[0];
  assign cnt     = cnt_r;
  assign any_hit = hit[QDEPTH-1];

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.del && hit[QDEPTH-1]) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/phased_timed_callback_queue_core.sv @@
// phased timed callback queue: four phases of every-tick sets and one-shot queues
// Commands arrive one beat each on in_*; results leave on out_* as beats.
// Every command yields one or more result beats, the final one flagged last.
// Add, remove and schedule answer with one acknowledge beat, pushed from
// the done state into the output register on out_*.
// Cancel removes one matching one-shot a cycle.
// Tick walks the every-tick set one client id a cycle, then pops one due
// one-shot a cycle from the phase's slot chain; either walk pauses while
// a beat is pending and the output is stalled.
// One command is in work at a time; in_stall is high until its last beat is
// in the output register.
// A stalled output holds its beat; work continues until a second beat waits.
// Reset empties every set and queue; no clearing pass is needed.
// depends on ptcq_pkg and ptcq_queue
`default_nettype none
module phased_timed_callback_queue_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ptcq_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ptcq_pkg::out_t      out_data
);
  import ptcq_pkg::*;

  state_e             state_r, state_nxt;
  logic [PH_W-1:0]    ph_r, ph_nxt;
  logic [CID_W-1:0]   cid_r, cid_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [SCAN_W-1:0]  sc_r, sc_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic               pend_v_r, pend_v_nxt;
  out_t               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic [CLIENTS-1:0] members_r [PHASES];
  logic [CLIENTS-1:0] members_nxt [PHASES];

  qctl_t              qctl [PHASES];
  entry_t             head [PHASES];
  logic [CNT_W-1:0]   cnt  [PHASES];
  logic [PHASES-1:0]  any_hit;

  logic   acc, can_push, cid_ok, k_ok;
  logic   ev_emit, ev_adv, due, emit_go, want_emit, push;
  out_t   emit_data, push_data;
  cmd_e   cmd;

  for (genvar p = 0; p < PHASES; p++) begin : g_q
    ptcq_queue u_queue (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (qctl[p]),
      .head    (head[p]),
      .cnt     (cnt[p]),
      .any_hit (any_hit[p])
    );
  end

  assign cmd      = cmd_e'(in_data.command);
  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign can_push = !out_valid_r || !out_stall;
  assign cid_ok   = (32'(in_data.client_id) < CLIENTS);
  assign k_ok     = (32'(k_r) < MAX_RESULTS);
  assign ev_emit  = members_r[ph_r][sc_r] && k_ok;
  assign ev_adv   = !ev_emit || !pend_v_r || can_push;
  assign due      = (cnt[ph_r] != '0) && (head[ph_r].deadline <= now_r) && k_ok;
  assign emit_go  = !pend_v_r || can_push;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (cmd == CMD_TICK) begin
            state_nxt = S_EVERY;
          end else if (cmd == CMD_CANCEL && cid_ok) begin
            state_nxt = S_CANCEL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_EVERY: begin
        if (ev_adv && sc_r == SCAN_W'(CLIENTS - 1)) state_nxt = S_POP;
      end
      S_POP: begin
        if (!due) state_nxt = S_DONE;
      end
      S_CANCEL: begin
        if (!any_hit[ph_r]) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (can_push) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ph_nxt      = ph_r;
    cid_nxt     = cid_r;
    now_nxt     = now_r;
    sc_nxt      = sc_r;
    k_nxt       = k_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    members_nxt = members_r;
    want_emit   = 1'b0;
    emit_data   = '0;
    push        = 1'b0;
    push_data   = '0;
    for (int p = 0; p < PHASES; p++) begin
      qctl[p]     = '0;
      qctl[p].dl  = in_data.now + in_data.delay;
      qctl[p].cid = (state_r == S_IDLE) ? in_data.client_id : cid_r;
    end
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          ph_nxt     = in_data.phase;
          cid_nxt    = in_data.client_id;
          now_nxt    = in_data.now;
          sc_nxt     = '0;
          k_nxt      = '0;
          pend_v_nxt = (cmd != CMD_TICK);
          pend_nxt   = '{fired_client: '0, fire_kind: KIND_ACK, status: ST_OK, last: 1'b1};
          if (cid_ok) begin
            if (cmd == CMD_ADD) begin
              members_nxt[in_data.phase][in_data.client_id] = 1'b1;
            end else if (cmd == CMD_REMOVE) begin
              members_nxt[in_data.phase][in_data.client_id] = 1'b0;
            end else if (cmd == CMD_SCHEDULE) begin
              if (cnt[in_data.phase] == CNT_W'(QDEPTH)) begin
                pend_nxt.status = ST_FULL;
              end else begin
                qctl[in_data.phase].ins = 1'b1;
              end
            end
          end
        end
      end
      S_EVERY: begin
        want_emit = ev_emit;
        emit_data = '{fired_client: CID_W'(sc_r), fire_kind: KIND_EVERY,
                      status: ST_OK, last: 1'b0};
        if (ev_adv) sc_nxt = sc_r + SCAN_W'(1);
      end
      S_POP: begin
        want_emit = due;
        emit_data = '{fired_client: head[ph_r].owner, fire_kind: KIND_ONESHOT,
                      status: ST_OK, last: 1'b0};
        qctl[ph_r].pop_mode = 1'b1;
        qctl[ph_r].del      = due && emit_go;
      end
      S_CANCEL: begin
        qctl[ph_r].del = 1'b1;
      end
      S_DONE: begin
        if (can_push) begin
          push       = 1'b1;
          push_data  = pend_v_r ? pend_r :
                       out_t'{fired_client: '0, fire_kind: KIND_ACK, status: ST_OK,
                              last: 1'b0};
          push_data.last = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    if (want_emit && emit_go) begin
      if (pend_v_r) begin
        push      = 1'b1;
        push_data = pend_r;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_data;
      k_nxt      = k_r + K_W'(1);
    end
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < PHASES; p++) members_r[p] <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      members_r   <= members_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    cid_r      <= cid_nxt;
    now_r      <= now_nxt;
    sc_r       <= sc_nxt;
    k_r        <= k_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cnt[0]) <= QDEPTH) && (32'(cnt[1]) <= QDEPTH) &&
    (32'(cnt[2]) <= QDEPTH) && (32'(cnt[3]) <= QDEPTH))
    else $error("one-shot count above queue depth");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && can_push) |=> (out_valid_r && out_data_r.last))
    else $error("command finished without a last beat");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fire_kind == KIND_ACK) |->
      (out_data_r.fired_client == '0 && out_data_r.last))
    else $error("acknowledge beat malformed");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(k_r) <= MAX_RESULTS) || state_r == S_IDLE)
    else $error("too many results for one tick");

endmodule
`default_nettype wire
